[hw/rtl/tmfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tmfp_pkg;

  // parse phase codes
  localparam logic [2:0] PH_BRACE    = 3'd0;
  localparam logic [2:0] PH_TAG      = 3'd1;
  localparam logic [2:0] PH_FIELDS   = 3'd2;
  localparam logic [2:0] PH_COMPLETE = 3'd3;
  localparam logic [2:0] PH_IGNORE   = 3'd4;

  // characters the parser looks for
  localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_NUL   = 8'h00;

  // tag names, first character in the lowest byte
  localparam logic [31:0] TAG_TIME = {8'h65, 8'h6D, 8'h69, 8'h74};  // "time"
  localparam logic [31:0] TAG_DATE = {8'h65, 8'h74, 8'h61, 8'h64};  // "date"
  localparam logic [31:0] TAG_TEMP = {8'h70, 8'h6D, 8'h65, 8'h74};  // "temp"

  // range limits and minimum message length
  localparam logic [7:0]  MAX_HOUR   = 8'd24;
  localparam logic [7:0]  MAX_MINSEC = 8'd60;
  localparam logic [15:0] MAX_DAY    = 16'd31;
  localparam logic [15:0] MAX_MONTH  = 16'd12;
  localparam logic [2:0]  MIN_LEN    = 3'd6;
  localparam logic [2:0]  TAG_LEN    = 3'd4;

  typedef enum logic [1:0] {
    KIND_TIME = 2'd0,
    KIND_DATE = 2'd1,
    KIND_TEMP = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_MALFORMED = 3'd0,
    ST_TIME_SET  = 3'd1,
    ST_DATE_SET  = 3'd2,
    ST_TEMP_SET  = 3'd3,
    ST_RANGE_REJ = 3'd4
  } status_e;

  typedef struct packed {
    status_e            status;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [15:0]        year;
    logic signed [7:0]  temperature;
  } result_t;

  // which known tag the collected characters form
  function automatic kind_e tag_kind(input logic [31:0] tag, input logic [2:0] len);
    kind_e k;
    k = KIND_NONE;
    if (len == TAG_LEN) begin
      if (tag == TAG_TIME) k = KIND_TIME;
      else if (tag == TAG_DATE) k = KIND_DATE;
      else if (tag == TAG_TEMP) k = KIND_TEMP;
    end
    return k;
  endfunction

  // delimiter that closes field idx of a message kind
  function automatic logic [7:0] field_delim(input kind_e k, input logic [1:0] idx);
    logic [7:0] d;
    d = CH_CLOSE;
    case (k)
      KIND_TIME: d = (idx == 2'd2) ? CH_CLOSE : CH_COLON;
      KIND_DATE: d = (idx == 2'd2) ? CH_CLOSE : CH_DOT;
      default:   d = CH_CLOSE;
    endcase
    return d;
  endfunction

  // number of fields of a message kind
  function automatic logic [1:0] field_total(input kind_e k);
    logic [1:0] n;
    case (k)
      KIND_TIME: n = 2'd3;
      KIND_DATE: n = 2'd3;
      default:   n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tmfp_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tmfp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

[hw/rtl/tmfp_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tmfp_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [4:0]        hour_out;
  logic [5:0]        minute_out;
  logic [5:0]        second_out;
  logic [4:0]        day_out;
  logic [3:0]        month_out;
  logic [15:0]       year_out;
  logic signed [7:0] temperature_out;

  modport source (
    output valid, output status, output hour_out, output minute_out, output second_out,
    output day_out, output month_out, output year_out, output temperature_out,
    input ready
  );
  modport sink (
    input valid, input status, input hour_out, input minute_out, input second_out,
    input day_out, input month_out, input year_out, input temperature_out,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/tmfp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module tmfp_parser import tmfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] char_i,
  input  wire logic       eos_i,
  output result_t         result_o
);

  logic [2:0]        phase_q, phase_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [31:0]       tag_q, tag_d;
  logic [2:0]        tag_len_q, tag_len_d;
  logic [1:0]        fidx_q, fidx_d;
  logic [15:0]       acc_q, acc_d;
  logic              sign_q, sign_d;
  logic              stop_q, stop_d;
  logic              seen_q, seen_d;
  logic [2:0][15:0]  staged_q, staged_d;
  logic              bad_q, bad_d;
  logic              ended_q, ended_d;
  logic [4:0]        hour_q, hour_d;
  logic [5:0]        min_q, min_d;
  logic [5:0]        sec_q, sec_d;
  logic [4:0]        day_q, day_d;
  logic [3:0]        mon_q, mon_d;
  logic [15:0]       year_q, year_d;
  logic [7:0]        temp_q, temp_d;

  kind_e             kind;
  logic [15:0]       field_val;
  logic [3:0]        digit;
  logic              is_digit;
  logic [7:0]        hh, mm, ss;
  status_e           status;

  assign kind      = tag_kind(tag_q, tag_len_q);
  assign field_val = sign_q ? 16'(16'd0 - acc_q) : acc_q;
  assign digit     = 4'(char_i - CH_ZERO);
  assign is_digit  = (char_i >= CH_ZERO) && (char_i <= CH_NINE);

  // per-byte parse step
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    tag_len_d = tag_len_q;
    fidx_d    = fidx_q;
    acc_d     = acc_q;
    sign_d    = sign_q;
    stop_d    = stop_q;
    seen_d    = seen_q;
    staged_d  = staged_q;
    bad_d     = bad_q;
    ended_d   = ended_q;
    if (take_i && !ended_q) begin
      if (char_i == CH_NUL) begin
        ended_d = 1'b1;
        if (phase_q != PH_COMPLETE) begin
          bad_d   = 1'b1;
          phase_d = PH_IGNORE;
        end
      end else begin
        if (cnt_q < MIN_LEN) cnt_d = 3'(cnt_q + 3'd1);
        case (phase_q)
          PH_BRACE: begin
            if (char_i == CH_OPEN) begin
              phase_d = PH_TAG;
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_IGNORE;
            end
          end
          PH_TAG: begin
            if (char_i == CH_SEMI) begin
              if (kind == KIND_NONE) begin
                bad_d   = 1'b1;
                phase_d = PH_IGNORE;
              end else begin
                phase_d = PH_FIELDS;
                fidx_d  = 2'd0;
                acc_d   = 16'd0;
                sign_d  = 1'b0;
                stop_d  = 1'b0;
                seen_d  = 1'b0;
              end
            end else if (tag_len_q < TAG_LEN) begin
              tag_d[tag_len_q[1:0]*8 +: 8] = char_i;
              tag_len_d = 3'(tag_len_q + 3'd1);
            end else begin
              bad_d   = 1'b1;
              phase_d = PH_IGNORE;
            end
          end
          PH_FIELDS: begin
            if (kind == KIND_NONE || fidx_q > 2'd2) begin
              bad_d   = 1'b1;
              phase_d = PH_IGNORE;
            end else if (char_i == field_delim(kind, fidx_q)) begin
              staged_d[fidx_q] = field_val;
              fidx_d = 2'(fidx_q + 2'd1);
              acc_d  = 16'd0;
              sign_d = 1'b0;
              stop_d = 1'b0;
              seen_d = 1'b0;
              if (2'(fidx_q + 2'd1) == field_total(kind)) phase_d = PH_COMPLETE;
            end else if (!seen_q && char_i == CH_MINUS) begin
              sign_d = 1'b1;
              seen_d = 1'b1;
            end else if (is_digit) begin
              if (!stop_q) acc_d = 16'((acc_q << 3) + (acc_q << 1) + {12'd0, digit});
              seen_d = 1'b1;
            end else begin
              stop_d = 1'b1;
              seen_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign hh = staged_d[0][7:0];
  assign mm = staged_d[1][7:0];
  assign ss = staged_d[2][7:0];

  // message end: range check and commit of the stored values
  always_comb begin
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    temp_d = temp_q;
    status = ST_MALFORMED;
    if (cnt_d >= MIN_LEN && !bad_d && phase_d == PH_COMPLETE && kind != KIND_NONE) begin
      case (kind)
        KIND_TIME: begin
          if (hh > MAX_HOUR || mm > MAX_MINSEC || ss > MAX_MINSEC) begin
            status = ST_RANGE_REJ;
          end else begin
            status = ST_TIME_SET;
            hour_d = hh[4:0];
            min_d  = mm[5:0];
            sec_d  = ss[5:0];
          end
        end
        KIND_DATE: begin
          if (staged_d[0] > MAX_DAY || staged_d[1] > MAX_MONTH || staged_d[1] == 16'd0) begin
            status = ST_RANGE_REJ;
          end else begin
            status = ST_DATE_SET;
            day_d  = staged_d[0][4:0];
            mon_d  = staged_d[1][3:0];
            year_d = staged_d[2];
          end
        end
        default: begin
          status = ST_TEMP_SET;
          temp_d = staged_d[0][7:0];
        end
      endcase
    end
  end

  // result of the message that ends with this byte
  always_comb begin
    result_o.status      = status;
    result_o.hour        = hour_d;
    result_o.minute      = min_d;
    result_o.second      = sec_d;
    result_o.day         = day_d;
    result_o.month       = mon_d;
    result_o.year        = year_d;
    result_o.temperature = signed'(temp_d);
  end

  // parse state, cleared after every final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BRACE;
      cnt_q     <= 3'd0;
      tag_q     <= 32'd0;
      tag_len_q <= 3'd0;
      fidx_q    <= 2'd0;
      acc_q     <= 16'd0;
      sign_q    <= 1'b0;
      stop_q    <= 1'b0;
      seen_q    <= 1'b0;
      staged_q  <= '0;
      bad_q     <= 1'b0;
      ended_q   <= 1'b0;
    end else if (take_i && eos_i) begin
      phase_q   <= PH_BRACE;
      cnt_q     <= 3'd0;
      tag_q     <= 32'd0;
      tag_len_q <= 3'd0;
      fidx_q    <= 2'd0;
      acc_q     <= 16'd0;
      sign_q    <= 1'b0;
      stop_q    <= 1'b0;
      seen_q    <= 1'b0;
      staged_q  <= '0;
      bad_q     <= 1'b0;
      ended_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      tag_q     <= tag_d;
      tag_len_q <= tag_len_d;
      fidx_q    <= fidx_d;
      acc_q     <= acc_d;
      sign_q    <= sign_d;
      stop_q    <= stop_d;
      seen_q    <= seen_d;
      staged_q  <= staged_d;
      bad_q     <= bad_d;
      ended_q   <= ended_d;
    end
  end

  // stored time, date and temperature
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q <= 5'd0;
      min_q  <= 6'd0;
      sec_q  <= 6'd0;
      day_q  <= 5'd0;
      mon_q  <= 4'd0;
      year_q <= 16'd0;
      temp_q <= 8'd0;
    end else if (take_i && eos_i) begin
      hour_q <= hour_d;
      min_q  <= min_d;
      sec_q  <= sec_d;
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      temp_q <= temp_d;
    end
  end

  // parse state is clean after each final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && eos_i |=> phase_q == PH_BRACE && cnt_q == 3'd0 && !ended_q && !bad_q)
    else $error("parse state not cleared after final byte");

  // the ignore phase and the bad flag go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IGNORE) == bad_q)
    else $error("ignore phase and bad flag disagree");

  // committed values are always in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hour_q <= 5'd24 && min_q <= 6'd60 && sec_q <= 6'd60 && mon_q <= 4'd12)
    else $error("stored value out of range");

  // a date set status always stores a nonzero month
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && eos_i && status == ST_DATE_SET |=> mon_q != 4'd0)
    else $error("date committed with month zero");

endmodule

`default_nettype wire

[hw/rtl/tmfp_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module tmfp_out_buf import tmfp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    head_q, head_d;
  result_t    skid_q, skid_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = head_q;

  // two-entry queue: head register plus skid register
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    skid_d = skid_q;
    if (push_i && pop) begin
      if (cnt_q == 2'd1) begin
        head_d = data_i;
      end else begin
        head_d = skid_q;
        skid_d = data_i;
      end
    end else if (pop) begin
      head_d = skid_q;
      cnt_d  = 2'(cnt_q - 2'd1);
    end else if (push_i) begin
      if (cnt_q == 2'd0) head_d = data_i;
      else skid_d = data_i;
      cnt_d = 2'(cnt_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  // occupancy never goes past two
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result queue overflow");

  // nothing is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full result queue");

  // a full queue that is not drained stays full with the same head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !ready_i |=> full_o && $stable(head_q))
    else $error("stalled full queue changed");

endmodule

`default_nettype wire

[hw/rtl/tagged_message_field_parser.sv]
// tagged message field parser
// parses {time;h:m:s}, {date;d.m.y} and {temp;n} messages one byte per request
// req_i: valid/ready channel with char_byte and end_of_string (final byte flag)
// rsp_o: valid/ready channel with status and all stored time, date and
//   temperature values; one response per message, raised by its final byte,
//   none for other bytes
// throughput: one byte per cycle while req_i.ready is high; each byte is
//   parsed in the cycle it is taken, against the parse state registers
// the response is computed combinationally from the final byte and is written
//   into the output queue when that byte is taken
// the output side is a two-entry queue (output register plus skid register);
//   bytes keep flowing while a response waits, and req_i.ready drops only when
//   both entries hold responses that the receiver has not taken
// reset: parse state returns to expecting '{', byte count to zero, stored
//   time, date and temperature to zero, queue empty; req_i.ready is high right
//   after reset, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module tagged_message_field_parser import tmfp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tmfp_req_if.sink    req_i,
  tmfp_rsp_if.source  rsp_o
);

  logic    take;
  logic    full;
  result_t result;
  result_t head;

  assign req_i.ready = !full;
  assign take        = req_i.valid && req_i.ready;

  // byte parser with stored values
  tmfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .char_i   (req_i.char_byte),
    .eos_i    (req_i.end_of_string),
    .result_o (result)
  );

  // response queue
  tmfp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && req_i.end_of_string),
    .data_i  (result),
    .full_o  (full),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (head)
  );

  // response payload
  assign rsp_o.status          = head.status;
  assign rsp_o.hour_out        = head.hour;
  assign rsp_o.minute_out      = head.minute;
  assign rsp_o.second_out      = head.second;
  assign rsp_o.day_out         = head.day;
  assign rsp_o.month_out       = head.month;
  assign rsp_o.year_out        = head.year;
  assign rsp_o.temperature_out = head.temperature;

endmodule

`default_nettype wire

[bench/tagged_message_field_parser_test.sv]
`timescale 1ns / 1ps

module tagged_message_field_parser_test;
  import tmfp_pkg::*;

  localparam int RANDOM_BYTES = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;

  // tracks the parse of every accepted byte and holds the reports it must produce
  class message_scoreboard;
    result_t     expected_reports[$];
    int          mismatches;

    logic [2:0]  phase;
    logic [2:0]  length_seen;
    logic [31:0] tag;
    logic [2:0]  tag_len;
    logic [1:0]  field_idx;
    logic [15:0] acc;
    bit          negative, stopped, started;
    logic [15:0] staged[3];
    bit          broken, text_done;
    logic [7:0]  held_time[3];
    logic [15:0] held_date[3];
    logic [7:0]  held_temp;

    function new();
      clear_parse();
      foreach (held_time[i]) held_time[i] = '0;
      foreach (held_date[i]) held_date[i] = '0;
      held_temp  = '0;
      mismatches = 0;
    endfunction

    function void clear_parse();
      phase       = PH_BRACE;
      length_seen = '0;
      tag         = '0;
      tag_len     = '0;
      field_idx   = '0;
      acc         = '0;
      negative    = 0;
      stopped     = 0;
      started     = 0;
      foreach (staged[i]) staged[i] = '0;
      broken      = 0;
      text_done   = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function kind_e message_kind();
      if (tag_len != TAG_LEN) return KIND_NONE;
      if (tag == TAG_TIME) return KIND_TIME;
      if (tag == TAG_DATE) return KIND_DATE;
      if (tag == TAG_TEMP) return KIND_TEMP;
      return KIND_NONE;
    endfunction

    // delimiter closing the current field
    function logic [7:0] closing_char(kind_e k, logic [1:0] idx);
      if (k == KIND_TEMP || idx == 2'd2) return CH_CLOSE;
      return (k == KIND_TIME) ? CH_COLON : CH_DOT;
    endfunction

    function void mark_broken();
      broken = 1;
      phase  = PH_IGNORE;
    endfunction

    function void start_field();
      acc      = '0;
      negative = 0;
      stopped  = 0;
      started  = 0;
    endfunction

    function void parse_char(logic [7:0] c);
      kind_e k;
      logic [1:0] field_count;
      case (phase)
        PH_BRACE: begin
          if (c == CH_OPEN) phase = PH_TAG;
          else mark_broken();
        end
        PH_TAG: begin
          if (c == CH_SEMI) begin
            if (message_kind() == KIND_NONE) begin
              mark_broken();
            end else begin
              phase     = PH_FIELDS;
              field_idx = '0;
              start_field();
            end
          end else if (tag_len < TAG_LEN) begin
            tag[8*tag_len +: 8] = c;
            tag_len++;
          end else begin
            mark_broken();
          end
        end
        PH_FIELDS: begin
          k = message_kind();
          field_count = (k == KIND_TEMP) ? 2'd1 : 2'd3;
          if (k == KIND_NONE || field_idx > 2'd2) begin
            mark_broken();
          end else if (c == closing_char(k, field_idx)) begin
            staged[field_idx] = negative ? 16'd0 - acc : acc;
            field_idx++;
            start_field();
            if (field_idx >= field_count) phase = PH_COMPLETE;
          end else if (!started && c == CH_MINUS) begin
            negative = 1;
            started  = 1;
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (!stopped) acc = acc * 16'd10 + 16'(c - CH_ZERO);
            started = 1;
          end else begin
            stopped = 1;
            started = 1;
          end
        end
        default: ;
      endcase
    endfunction

    // range check and commit on the final byte
    function status_e commit_message();
      kind_e k;
      logic [7:0] h, m, s;
      k = message_kind();
      if (length_seen < MIN_LEN || broken || phase != PH_COMPLETE || k == KIND_NONE)
        return ST_MALFORMED;
      case (k)
        KIND_TIME: begin
          h = staged[0][7:0];
          m = staged[1][7:0];
          s = staged[2][7:0];
          if (h > MAX_HOUR || m > MAX_MINSEC || s > MAX_MINSEC) return ST_RANGE_REJ;
          held_time[0] = h;
          held_time[1] = m;
          held_time[2] = s;
          return ST_TIME_SET;
        end
        KIND_DATE: begin
          if (staged[0] > MAX_DAY || staged[1] > MAX_MONTH || staged[1] == 16'd0)
            return ST_RANGE_REJ;
          foreach (held_date[i]) held_date[i] = staged[i];
          return ST_DATE_SET;
        end
        default: begin
          held_temp = staged[0][7:0];
          return ST_TEMP_SET;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] c, bit last);
      result_t report;
      if (!text_done) begin
        if (c == CH_NUL) begin
          text_done = 1;
          if (phase != PH_COMPLETE) mark_broken();
        end else begin
          if (length_seen < MIN_LEN) length_seen++;
          parse_char(c);
        end
      end
      if (last) begin
        report.status      = commit_message();
        report.hour        = held_time[0][4:0];
        report.minute      = held_time[1][5:0];
        report.second      = held_time[2][5:0];
        report.day         = held_date[0][4:0];
        report.month       = held_date[1][3:0];
        report.year        = held_date[2];
        report.temperature = held_temp;
        expected_reports.push_back(report);
        clear_parse();
      end
    endfunction

    function void compare_field(string name, int want, int seen);
      if (want != seen) begin
        $error("%s: expected %0d, actual %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (expected_reports.size() == 0) begin
        $error("response with no message pending: status %0d", seen.status);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status", int'(want.status), int'(seen.status));
      compare_field("hour_out", want.hour, seen.hour);
      compare_field("minute_out", want.minute, seen.minute);
      compare_field("second_out", want.second, seen.second);
      compare_field("day_out", want.day, seen.day);
      compare_field("month_out", want.month, seen.month);
      compare_field("year_out", want.year, seen.year);
      compare_field("temperature_out", int'(want.temperature), int'(seen.temperature));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tmfp_req_if req_if ();
  tmfp_rsp_if rsp_if ();

  tagged_message_field_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  message_scoreboard sb = new();
  logic [7:0] msg[$];
  int bytes_sent;
  int quiet_msgs;
  int cycle_count;
  result_t taken_report;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tagged_message_field_parser regression: fail");
      $finish;
    end
  end

  // check every response taken
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      taken_report.status      = status_e'(rsp_if.status);
      taken_report.hour        = rsp_if.hour_out;
      taken_report.minute      = rsp_if.minute_out;
      taken_report.second      = rsp_if.second_out;
      taken_report.day         = rsp_if.day_out;
      taken_report.month       = rsp_if.month_out;
      taken_report.year        = rsp_if.year_out;
      taken_report.temperature = rsp_if.temperature_out;
      sb.check_result(taken_report);
    end
  end

  // response side: random stall before each response, with calm stretches
  initial begin : response_taker
    int stall;
    int calm_left;
    calm_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (calm_left > 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(4, 12);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk_i);
    end
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endfunction

  function automatic void put_tag(logic [31:0] t);
    for (int i = 0; i < 4; i++) msg.push_back(t[8*i +: 8]);
  endfunction

  // text of one decimal field, biased toward the range limit
  function automatic string field_text(int top);
    string junk_pool[5] = '{"x", "+", "-", " ", "/"};
    case ($urandom_range(0, 9))
      0, 1, 2: return $sformatf("%0d", $urandom_range(0, top));
      3:       return $sformatf("%0d", top + int'($urandom_range(1, 3)));
      4:       return $sformatf("%0d", top);
      5:       return $sformatf("-%0d", $urandom_range(0, 300));
      6:       return $sformatf("%0d", $urandom_range(0, 999999));
      7:       return "";
      8:       return $sformatf("%0d%s%0d", $urandom_range(0, 99),
                                junk_pool[$urandom_range(0, 4)], $urandom_range(0, 9));
      default: return "-";
    endcase
  endfunction

  function automatic void put_good_message();
    case ($urandom_range(0, 2))
      0: begin
        msg.push_back(CH_OPEN);
        put_tag(TAG_TIME);
        msg.push_back(CH_SEMI);
        put_text(field_text(24));
        msg.push_back(CH_COLON);
        put_text(field_text(60));
        msg.push_back(CH_COLON);
        put_text(field_text(60));
      end
      1: begin
        msg.push_back(CH_OPEN);
        put_tag(TAG_DATE);
        msg.push_back(CH_SEMI);
        put_text(field_text(31));
        msg.push_back(CH_DOT);
        put_text(field_text(12));
        msg.push_back(CH_DOT);
        put_text(field_text(65535));
      end
      default: begin
        msg.push_back(CH_OPEN);
        put_tag(TAG_TEMP);
        msg.push_back(CH_SEMI);
        put_text(field_text(127));
      end
    endcase
    msg.push_back(CH_CLOSE);
    if ($urandom_range(0, 7) == 0) put_text("zz");
  endfunction

  // tag of the wrong length, a near miss, or a tag with no semicolon
  function automatic void put_bad_tag_message();
    string letters = "timedapx";
    bit skip_semi;
    skip_semi = 0;
    msg.push_back(CH_OPEN);
    case ($urandom_range(0, 3))
      0: repeat ($urandom_range(0, 6)) msg.push_back(letters[$urandom_range(0, 7)]);
      1: put_tag(TAG_TEMP ^ (32'h20 << (8 * $urandom_range(0, 3))));
      2: begin
        put_tag(TAG_DATE);
        msg.push_back(letters[$urandom_range(0, 7)]);
      end
      default: begin
        put_tag(TAG_TIME);
        skip_semi = 1;
      end
    endcase
    if (!skip_semi) msg.push_back(CH_SEMI);
    put_text(field_text(99));
    msg.push_back(CH_CLOSE);
  endfunction

  function automatic void build_random_message();
    int pick;
    msg.delete();
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      put_good_message();
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 84) begin
      // cut short before the end
      put_good_message();
      msg = msg[0 : $urandom_range(0, msg.size() - 2)];
    end else if (pick < 90) begin
      put_bad_tag_message();
    end else if (pick < 95) begin
      // text ends at a zero byte, junk after it
      put_good_message();
      msg.insert($urandom_range(1, msg.size()), CH_NUL);
      repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_good_message();
      msg[0] = 8'($urandom_range(0, 255));
    end
  endfunction

  // send msg byte by byte, random gap before each request
  task automatic send_message();
    int gap;
    bit last;
    bit calm;
    if (quiet_msgs > 0) quiet_msgs--;
    else if ($urandom_range(0, 5) == 0) quiet_msgs = $urandom_range(1, 4);
    calm = (quiet_msgs > 0);
    for (int i = 0; i < msg.size(); i++) begin
      gap  = calm ? 0 : $urandom_range(0, 3);
      last = (i == msg.size() - 1);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      req_if.valid         <= 1'b1;
      req_if.char_byte     <= msg[i];
      req_if.end_of_string <= last;
      do @(posedge clk_i); while (!req_if.ready);
      sb.note_byte(msg[i], last);
      bytes_sent++;
      @(negedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    msg.delete();
    put_text(s);
    send_message();
  endtask

  // hold off the sender until every response is back
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin : byte_sender
    int random_start;
    int msg_count;
    bytes_sent           = 0;
    quiet_msgs           = 0;
    msg_count            = 0;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.char_byte     <= '0;
    req_if.end_of_string <= 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // limits, range rejects, wrap and stop characters
    send_text("{time;24:60:60}");
    send_text("{time;25:0:0}");
    send_text("{date;31.12.65535}");
    send_text("{date;1.0.70000}");
    send_text("{temp;-128}");
    send_text("{temp;-5x9}");
    // bad start, tag too short, too long, unknown, missing delimiter
    send_text("x");
    send_text("{tim;1}");
    send_text("{times;1}");
    send_text("{tame;5}");
    send_text("{time;1:2");
    // bytes after the closing brace
    send_text("{temp;3}zz");
    // zero byte ends the text, late and early
    msg.delete();
    put_text("{temp;4}");
    msg.push_back(CH_NUL);
    msg.push_back(8'hFF);
    send_message();
    msg.delete();
    put_text("{te");
    msg.push_back(CH_NUL);
    put_text("mp;5}");
    send_message();
    // high bytes
    msg.delete();
    msg.push_back(CH_OPEN);
    msg.push_back(8'hFF);
    msg.push_back(8'h80);
    send_message();
    wait_for_drain();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_random_message();
      send_message();
      msg_count++;
      if (msg_count % 30 == 0) wait_for_drain();
    end
    req_if.valid <= 1'b0;

    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0)
      $display("tagged_message_field_parser regression: pass");
    else
      $display("tagged_message_field_parser regression: fail");
    $finish;
  end

endmodule

[tagged_message_field_parser.f]
hw/rtl/tmfp_pkg.sv
hw/rtl/tmfp_req_if.sv
hw/rtl/tmfp_rsp_if.sv
hw/rtl/tmfp_parser.sv
hw/rtl/tmfp_out_buf.sv
hw/rtl/tagged_message_field_parser.sv
bench/tagged_message_field_parser_test.sv
